[rtl/cfb_pkg.sv]
// Package: shared constants, job descriptor type and command table for the frame builder.
package cfb_pkg;

  localparam int CFB_LEN_W       = 10;
  localparam int CFB_MAX_PAYLOAD = 800;
  localparam int CFB_JOB_BYTES   = 6;
  localparam int CFB_CNT_W       = 3;
  localparam int CFB_QUEUE_DEPTH = 4;
  localparam int CFB_QPTR_W      = $clog2(CFB_QUEUE_DEPTH);
  localparam int CFB_QCNT_W      = $clog2(CFB_QUEUE_DEPTH + 1);

  localparam logic [7:0] CFB_START_CODE = 8'hF5;
  localparam logic [7:0] CFB_END_CODE   = 8'h5F;
  localparam logic [7:0] CFB_MAIN_CTRL  = 8'hFF;
  localparam logic [7:0] CFB_MAIN_CMD   = 8'h03;

  // Request kinds carried on tuser
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // Command codes with special handling
  localparam logic [4:0] CMD_OK          = 5'd0;
  localparam logic [4:0] CMD_ERROR       = 5'd1;
  localparam logic [4:0] CMD_UART_BYPASS = 5'd9;
  localparam logic [4:0] CMD_SEND_IR     = 5'd13;

  // One queued job: the bytes to emit, lowest index first, and how many
  typedef struct packed {
    logic [CFB_JOB_BYTES-1:0][7:0] bytes;
    logic [CFB_CNT_W-1:0]          cnt;
  } job_t;

  // Sub command byte for a known command code
  function automatic logic [7:0] sub_byte(input logic [3:0] code);
    logic [7:0] b;
    unique case (code)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h03;
      4'd3:    b = 8'h04;
      4'd4:    b = 8'h05;
      4'd5:    b = 8'h06;
      4'd6:    b = 8'h07;
      4'd7:    b = 8'h08;
      4'd8:    b = 8'h0A;
      4'd9:    b = 8'hFF;
      4'd10:   b = 8'h0B;
      4'd11:   b = 8'h0C;
      4'd12:   b = 8'h0D;
      4'd13:   b = 8'h0E;
      4'd14:   b = 8'h19;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

[rtl/command_frame_builder_unit.sv]
// Top level: command frame builder, front end, job queue and byte sequencer.
//
// Input channel in_*: tuser selects the request (0 start a frame, 1 one payload
// byte); tdata carries cmd_code, payload_len and data_byte. A start emits the
// header F5, main, sub, length low byte, the high byte for two-byte-length
// commands, and 5F at once when the length is zero. Each payload byte of an
// open frame passes through, followed by 5F after the last one. Payload with
// no open frame is dropped; a new start abandons an open frame.
// Output channel out_*: one frame byte per transaction, tlast marks the last
// byte caused by one input transaction.
// The first byte of a job passes through the job queue and the output register.
// Throughput: one input transaction per cycle while the job queue has room;
// the output side moves one byte per cycle while the receiver takes them, so
// a multi-byte job holds the byte sequencer and the four-entry queue absorbs
// the rest. Reset: frame state, queue and output register clear; in_tready
// goes high once a clock edge samples reset. A stalled receiver holds the
// output byte and backs up into the queue, which drops in_tready once full.
module command_frame_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [4:0] cmd_code, [20:5] payload_len, [28:21] data_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast   // last
);
  import cfb_pkg::*;

  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  cfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  cfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  cfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (queue_empty),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/cfb_front.sv]
// Front end: accepts requests, tracks the open frame and builds byte jobs.
module cfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [4:0] cmd_code, [20:5] payload_len, [28:21] data_byte
  input  logic              in_tuser,   // [0] req_type
  input  logic              queue_full,
  output logic              push,
  output cfb_pkg::job_t     push_job
);
  import cfb_pkg::*;

  logic                 frame_open_r, frame_open_nxt;
  logic [CFB_LEN_W-1:0] bytes_left_r, bytes_left_nxt;

  logic [4:0]           cmd_code;
  logic [15:0]          payload_len;
  logic [7:0]           data_byte;
  logic                 accept;
  logic                 known;
  logic                 ctrl_cmd;
  logic                 two;
  logic [15:0]          len_raw;
  logic [CFB_LEN_W-1:0] len_c;
  logic [7:0]           main_b;
  logic [7:0]           sub_b;
  logic                 close;

  assign cmd_code    = in_tdata[4:0];
  assign payload_len = in_tdata[20:5];
  assign data_byte   = in_tdata[28:21];
  assign in_tready   = !queue_full;
  assign accept      = in_tvalid && in_tready;

  // Classify the request and build its job
  always_comb begin
    known    = !cmd_code[4];
    ctrl_cmd = known && (cmd_code == CMD_OK || cmd_code == CMD_ERROR);
    two      = known && (cmd_code == CMD_UART_BYPASS || cmd_code == CMD_SEND_IR);
    main_b   = !known ? 8'h00 : (ctrl_cmd ? CFB_MAIN_CTRL : CFB_MAIN_CMD);
    sub_b    = known ? sub_byte(cmd_code[3:0]) : 8'h00;
    len_raw  = ctrl_cmd ? 16'd0 : payload_len;
    len_c    = (len_raw > 16'(CFB_MAX_PAYLOAD)) ? CFB_LEN_W'(CFB_MAX_PAYLOAD)
                                                : len_raw[CFB_LEN_W-1:0];
    push_job       = '0;
    push           = 1'b0;
    close          = 1'b0;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    if (in_tuser == REQ_START) begin
      close             = (len_c == '0);
      push_job.bytes[0] = CFB_START_CODE;
      push_job.bytes[1] = main_b;
      push_job.bytes[2] = sub_b;
      push_job.bytes[3] = len_c[7:0];
      push_job.bytes[4] = two ? 8'(len_c >> 8) : CFB_END_CODE;
      push_job.bytes[5] = CFB_END_CODE;
      push_job.cnt      = CFB_CNT_W'(4) + CFB_CNT_W'(two) + CFB_CNT_W'(close);
      push              = accept;
      if (accept) begin
        frame_open_nxt = !close;
        bytes_left_nxt = len_c;
      end
    end else begin
      close             = (bytes_left_r <= CFB_LEN_W'(1));
      push_job.bytes[0] = data_byte;
      push_job.bytes[1] = CFB_END_CODE;
      push_job.cnt      = CFB_CNT_W'(1) + CFB_CNT_W'(close);
      push              = accept && frame_open_r;
      if (push) begin
        if (bytes_left_r != '0) bytes_left_nxt = bytes_left_r - CFB_LEN_W'(1);
        if (close) frame_open_nxt = 1'b0;
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

[rtl/cfb_queue.sv]
// Job queue: a short FIFO between the front end and the byte sequencer.
module cfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cfb_pkg::job_t head_job
);
  import cfb_pkg::*;

  job_t                  slots_r [CFB_QUEUE_DEPTH];
  logic [CFB_QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CFB_QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CFB_QCNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = (count_r == CFB_QCNT_W'(CFB_QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == CFB_QPTR_W'(CFB_QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + CFB_QPTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == CFB_QPTR_W'(CFB_QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + CFB_QPTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CFB_QCNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CFB_QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store job payload
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_job;
  end

endmodule

[rtl/cfb_back.sv]
// Back end: walks each queued job byte by byte into the output register.
module cfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  cfb_pkg::job_t head_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,   // [7:0] out_byte
  output logic          out_tlast    // last
);
  import cfb_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [CFB_CNT_W-1:0] step_r, step_nxt;
  logic                 load;
  logic                 at_end;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Load a new byte whenever the output register is free or being taken
  always_comb begin
    load          = !out_valid_r || out_tready;
    at_end        = (step_r == head_job.cnt - CFB_CNT_W'(1));
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    step_nxt      = step_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_data_nxt = head_job.bytes[step_r];
        out_last_nxt = at_end;
        if (at_end) begin
          pop      = 1'b1;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + CFB_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[rtl/cfb_checker.sv]
// Checker: port-level properties of the frame builder, bound to the top level.
module cfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Output register is empty right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Queue is empty after reset, so input is accepted
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // Stalled output transaction holds its byte and marker
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

endmodule

bind command_frame_builder_unit cfb_checker u_cfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[sim/tb_command_frame_builder_unit.sv]
// Self-checking testbench for command_frame_builder_unit: frame header, payload and close bytes.
module tb_command_frame_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int          RESET_CYCLES   = 9;
  localparam int          SETTLE_CYCLES  = 24;
  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          LONG_HOLD      = 400;
  localparam int          HOLD_AT_BYTE   = 60;
  localparam int          N_KNOWN_CMDS   = 16;
  localparam int          RANDOM_ITEMS   = 160;
  localparam int          LONG_FRAME_LEN = 40;

  localparam logic [4:0]  CMD_SWITCH_INPUT = 5'd2;
  localparam logic [4:0]  CMD_GET_LOCAL_ID = 5'd4;
  localparam logic [4:0]  CMD_SET_EDID     = 5'd8;
  localparam logic [4:0]  CMD_UNKNOWN_TOP  = 5'd31;

  // Sub command byte per known code, code 0 in the lowest byte
  localparam logic [15:0][7:0] SUB_OF = {
    8'h20, 8'h19, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'hFF, 8'h0A,
    8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h01, 8'h00
  };

  typedef struct {
    logic        req_type;
    logic [4:0]  cmd_code;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
    logic        drain_first;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  frame_req_t  req_q[$];
  frame_byte_t bytes_due[$];

  // Predictor state
  logic        open_frame = 1'b0;
  logic [9:0]  payload_left = '0;

  int unsigned n_fail = 0;
  int unsigned n_accepted = 0;
  int unsigned n_starts = 0;
  int unsigned n_payloads = 0;
  int unsigned n_bytes = 0;
  int unsigned n_in_stalls = 0;
  int unsigned n_cycles = 0;

  command_frame_builder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the frame bytes one accepted transaction causes and advance the frame state
  function automatic void predict_frame_bytes(input logic req, input logic [4:0] code,
                                              input logic [15:0] len_in,
                                              input logic [7:0] data);
    logic [7:0]  seq[$];
    logic [7:0]  main_b;
    logic [7:0]  sub_b;
    logic [15:0] len;
    logic        wide;
    main_b = 8'h00;
    sub_b  = 8'h00;
    wide   = 1'b0;
    len    = len_in;
    if (req == REQ_START) begin
      if (code < N_KNOWN_CMDS) begin
        sub_b  = SUB_OF[code[3:0]];
        main_b = CFB_MAIN_CMD;
        if (code == CMD_OK || code == CMD_ERROR) begin
          main_b = CFB_MAIN_CTRL;
          len    = '0;
        end
        wide = (code == CMD_UART_BYPASS || code == CMD_SEND_IR);
      end
      if (len > 16'(CFB_MAX_PAYLOAD)) len = 16'(CFB_MAX_PAYLOAD);
      seq = '{CFB_START_CODE, main_b, sub_b, len[7:0]};
      if (wide) seq.push_back(len[15:8]);
      if (len == 0) begin
        seq.push_back(CFB_END_CODE);
        open_frame   = 1'b0;
        payload_left = '0;
      end else begin
        open_frame   = 1'b1;
        payload_left = len[9:0];
      end
    end else if (open_frame) begin
      seq.push_back(data);
      if (payload_left != 0) payload_left--;
      if (payload_left == 0) begin
        seq.push_back(CFB_END_CODE);
        open_frame = 1'b0;
      end
    end
    foreach (seq[i]) bytes_due.push_back('{value: seq[i], is_last: (i == seq.size() - 1)});
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Queue a start; the unused data byte gets random content
  task automatic add_start(input logic [4:0] code, input logic [15:0] len,
                           input logic drain);
    req_q.push_back('{REQ_START, code, len, 8'($urandom), drain});
  endtask

  // Queue a payload byte; the unused code and length get random content
  task automatic add_payload(input logic [7:0] data);
    req_q.push_back('{REQ_PAYLOAD, 5'($urandom), 16'($urandom), data, 1'b0});
  endtask

  // Driver: present queued requests with random gaps, predict on each accepted transaction
  always @(posedge clk) begin : drv
    frame_req_t  nxt;
    logic        offer;
    int unsigned gap_left;
    offer = in_tvalid;
    if (!rst_n) begin
      offer    = 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && !in_tready) n_in_stalls++;
      if (in_tvalid && in_tready) begin
        predict_frame_bytes(in_tuser, in_tdata[4:0], in_tdata[20:5], in_tdata[28:21]);
        n_accepted++;
        if (in_tuser == REQ_START) n_starts++;
        else n_payloads++;
        offer    = 1'b0;
        gap_left = pick_gap(((n_accepted / 24) % 4) == 3);
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].drain_first && bytes_due.size() != 0)) begin
          nxt = req_q.pop_front();
          in_tuser <= nxt.req_type;
          in_tdata <= {3'b000, nxt.data_byte, nxt.payload_len, nxt.cmd_code};
          offer = 1'b1;
        end
      end
    end
    in_tvalid <= offer;
  end

  // Monitor: check each frame byte against the oldest expectation, stall the receiver at random
  always @(posedge clk) begin : mon
    frame_byte_t exp_b;
    logic        rdy;
    logic        long_hold_done;
    int unsigned hold_left;
    rdy = 1'b0;
    if (!rst_n) begin
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_bytes++;
        if (bytes_due.size() == 0) begin
          $error("unexpected frame byte %02h (last %0b)", out_tdata, out_tlast);
          n_fail++;
        end else begin
          exp_b = bytes_due.pop_front();
          if (out_tdata !== exp_b.value) begin
            $error("out_byte: expected %02h, actual %02h", exp_b.value, out_tdata);
            n_fail++;
          end
          if (out_tlast !== exp_b.is_last) begin
            $error("last: expected %0b, actual %0b", exp_b.is_last, out_tlast);
            n_fail++;
          end
        end
        // Hold off once for a long stretch so the job queue fills and the input stalls
        if (n_bytes == HOLD_AT_BYTE && !long_hold_done) begin
          hold_left      = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          hold_left = pick_gap(((n_bytes / 32) % 4) == 1);
        end
      end
      if (hold_left != 0) hold_left--;
      else rdy = 1'b1;
    end
    out_tready <= rdy;
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL command_frame_builder_unit");
      $finish;
    end
  end

  initial begin : stim
    int unsigned n_rand;
    int unsigned pick;
    int unsigned sel;
    int unsigned eff;
    int unsigned cnt;
    logic [4:0]  code;
    logic [15:0] len;

    // Directed: every code with a zero or forced length
    for (int c = 0; c < N_KNOWN_CMDS; c++) begin
      if (c == CMD_OK) add_start(5'(c), 16'hFFFF, 1'b0);
      else if (c == CMD_ERROR) add_start(5'(c), 16'd5, 1'b0);
      else add_start(5'(c), 16'd0, 1'b0);
    end
    // Two-byte length frame run to its close
    add_start(CMD_UART_BYPASS, 16'd2, 1'b0);
    add_payload(8'h00);
    add_payload(8'hFF);
    // Stray payload with no open frame
    add_payload(8'hA5);
    // One-byte length above 255, abandoned by an unknown code with a clamped length
    add_start(CMD_GET_LOCAL_ID, 16'd300, 1'b0);
    add_payload(8'h5F);
    add_start(CMD_UNKNOWN_TOP, 16'hFFFF, 1'b0);
    add_payload(8'hF5);
    // Clamped two-byte length abandoned at once, then a drained one-byte frame
    add_start(CMD_SEND_IR, 16'd1000, 1'b0);
    add_start(CMD_SWITCH_INPUT, 16'd1, 1'b1);
    add_payload(8'h3C);

    // One full frame, longer than the short random ones, run to its close
    add_start(CMD_SET_EDID, 16'(LONG_FRAME_LEN), 1'b0);
    repeat (LONG_FRAME_LEN) add_payload(8'($urandom));

    // Random frames: mostly well formed, some cut short, overrun or stray
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        add_payload(8'($urandom));
      end else begin
        code = 5'($urandom_range(0, 31));
        sel  = $urandom_range(0, 99);
        if (sel < 55) len = 16'($urandom_range(0, 4));
        else if (sel < 85) len = 16'($urandom_range(5, 16));
        else len = 16'($urandom_range(0, 65535));
        add_start(code, len, $urandom_range(0, 19) == 0);
        n_rand++;
        if (code == CMD_OK || code == CMD_ERROR) eff = 0;
        else if (len > CFB_MAX_PAYLOAD) eff = CFB_MAX_PAYLOAD;
        else eff = len;
        if (eff > 16) begin
          cnt = $urandom_range(0, 5);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 80) cnt = eff;
          else if (sel < 90) cnt = $urandom_range(0, eff);
          else cnt = eff + $urandom_range(1, 3);
        end
        repeat (cnt) add_payload(8'($urandom));
        n_rand += cnt;
      end
    end

    // Reset once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all requests to go in and all frame bytes to come out
    while (req_q.size() != 0 || in_tvalid || bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d frame starts and %0d payload bytes; %0d frame bytes checked.",
             n_starts, n_payloads, n_bytes);
    $display("Input back-pressure seen on %0d cycles; %0d mismatches.", n_in_stalls, n_fail);
    if (n_fail == 0 && bytes_due.size() == 0) begin
      $display("PASS command_frame_builder_unit");
    end else begin
      $display("FAIL command_frame_builder_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cfb_pkg.sv
rtl/cfb_front.sv
rtl/cfb_queue.sv
rtl/cfb_back.sv
rtl/command_frame_builder_unit.sv
rtl/cfb_checker.sv
sim/tb_command_frame_builder_unit.sv
